// ----- hdl/sse_pkg.sv -----
// ============================================================================
// sse_pkg - shared types and constants for the sorted set engine
// Holds the request commands, result status codes, the sweep token that
// travels along the row of cells, and the controller state type.
// ============================================================================
`default_nettype none

package sse_pkg;

	localparam int DATA_W       = 32;
	localparam int CAPACITY_DEF = 16;
	localparam int STATUS_W     = 3;
	localparam int COUNT_OUT_W  = 5;

	localparam logic [1:0] CMD_INSERT = 2'd0;
	localparam logic [1:0] CMD_DELETE = 2'd1;

	localparam logic [STATUS_W-1:0] ST_INSERTED  = 3'd0;
	localparam logic [STATUS_W-1:0] ST_DUPLICATE = 3'd1;
	localparam logic [STATUS_W-1:0] ST_DELETED   = 3'd2;
	localparam logic [STATUS_W-1:0] ST_NOT_FOUND = 3'd3;
	localparam logic [STATUS_W-1:0] ST_FOUND     = 3'd4;
	localparam logic [STATUS_W-1:0] ST_FULL      = 3'd5;

	typedef enum logic [1:0] {
		OP_INSERT,
		OP_DELETE,
		OP_SEARCH
	} op_t;

	typedef struct packed {
		logic                     active;
		op_t                      op;
		logic                     full;
		logic                     found;
		logic                     hit;
		logic signed [DATA_W-1:0] key;
		logic signed [DATA_W-1:0] carry;
	} tok_t;

	typedef enum logic [1:0] {
		S_IDLE,
		S_BUSY,
		S_HOLD
	} state_t;

endpackage

`default_nettype wire

// ----- hdl/sse_cell.sv -----
// ============================================================================
// sse_cell - one storage cell of the sorted set row
// Holds one entry and passes the request token to its upper neighbor each
// cycle, inserting the key or shifting entries as the token sweeps past.
// ============================================================================
`default_nettype none

module sse_cell #(
	parameter int IDX = 0,
	parameter int CW  = 5
) (
	input  wire logic                             clk,
	input  wire logic                             arst_n,
	input  wire sse_pkg::tok_t                    tok_in,
	input  wire logic [CW-1:0]                    count,
	input  wire logic signed [sse_pkg::DATA_W-1:0] next_entry,
	output logic signed [sse_pkg::DATA_W-1:0]     entry,
	output sse_pkg::tok_t                         tok_out
);

	localparam logic [CW-1:0] IDX_C = CW'(IDX);

	logic signed [sse_pkg::DATA_W-1:0] entry_q;
	logic signed [sse_pkg::DATA_W-1:0] entry_nxt;
	sse_pkg::tok_t                     tok_q;
	sse_pkg::tok_t                     tok_nxt;
	logic                              valid;
	logic                              ge;
	logic                              eq;

	always_comb begin
		valid     = IDX_C < count;
		ge        = entry_q >= tok_in.key;
		eq        = entry_q == tok_in.key;
		tok_nxt   = tok_in;
		entry_nxt = entry_q;
		if (tok_in.active) begin
			if (!tok_in.found) begin
				if (!valid || ge) begin
					tok_nxt.found = 1'b1;
					tok_nxt.hit   = valid && eq;
					case (tok_in.op)
						sse_pkg::OP_INSERT: begin
							if (!tok_in.full && !(valid && eq)) begin
								entry_nxt     = tok_in.key;
								tok_nxt.carry = entry_q;
							end
						end
						sse_pkg::OP_DELETE: begin
							if (valid && eq) begin
								entry_nxt = next_entry;
							end
						end
						default: begin
						end
					endcase
				end
			end else begin
				case (tok_in.op)
					sse_pkg::OP_INSERT: begin
						if (!tok_in.full && !tok_in.hit) begin
							entry_nxt     = tok_in.carry;
							tok_nxt.carry = entry_q;
						end
					end
					sse_pkg::OP_DELETE: begin
						if (tok_in.hit) begin
							entry_nxt = next_entry;
						end
					end
					default: begin
					end
				endcase
			end
		end
	end

	always_ff @(posedge clk) begin
		entry_q <= entry_nxt;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tok_q <= '0;
		end else begin
			tok_q <= tok_nxt;
		end
	end

	assign entry   = entry_q;
	assign tok_out = tok_q;

endmodule

`default_nettype wire

// ----- hdl/sorted_set_engine.sv -----
// ============================================================================
// sorted_set_engine - sorted set of distinct signed values in a cell row
// Inserts, deletes and looks up keys; every request returns a status and
// the number of entries held afterwards.
// ============================================================================
//
//   Channel   Handshake              Payload
//   request   req_valid, req_ready   command, key_value
//   response  rsp_valid, rsp_ready   status, entry_count
//
// A request sweeps the row of CAPACITY cells, one cell per cycle: it is
// registered in the head token, then in each cell's token register, and its
// result is registered at the output; the next request waits for that result.
// A response that is held off by rsp_ready is parked in one buffer stage;
// a further request is taken only once that buffer is empty.
// Reset empties the set; entries need no clearing pass.
`default_nettype none

module sorted_set_engine #(
	parameter int CAPACITY = sse_pkg::CAPACITY_DEF
) (
	input  wire logic                               clk,
	input  wire logic                               arst_n,
	input  wire logic                               req_valid,
	output logic                                    req_ready,
	input  wire logic [1:0]                         command,
	input  wire logic signed [sse_pkg::DATA_W-1:0]  key_value,
	output logic                                    rsp_valid,
	input  wire logic                               rsp_ready,
	output logic [sse_pkg::STATUS_W-1:0]            status,
	output logic [sse_pkg::COUNT_OUT_W-1:0]         entry_count
);

	localparam int CW = $clog2(CAPACITY + 1);
	localparam logic [CW-1:0] CAP_C = CW'(CAPACITY);

	sse_pkg::state_t state_q;
	sse_pkg::state_t state_nxt;
	sse_pkg::tok_t   head_q;
	sse_pkg::tok_t   head_nxt;
	sse_pkg::tok_t   tok_w [CAPACITY+1];
	logic signed [sse_pkg::DATA_W-1:0] ent_w [CAPACITY];

	logic [CW-1:0]                      count_q;
	logic [CW-1:0]                      count_nxt;
	logic                               rsp_valid_q;
	logic                               rsp_valid_nxt;
	logic [sse_pkg::STATUS_W-1:0]       status_q;
	logic [sse_pkg::COUNT_OUT_W-1:0]    cnt_out_q;
	logic [sse_pkg::STATUS_W-1:0]       pend_status_q;
	logic [sse_pkg::COUNT_OUT_W-1:0]    pend_cnt_q;
	logic                               load_out;
	logic                               load_pend;
	logic                               from_pend;
	logic                               out_free;
	logic [sse_pkg::STATUS_W-1:0]       res_status;
	logic [CW+sse_pkg::COUNT_OUT_W-1:0] res_cnt_ext;
	sse_pkg::tok_t                      exit_tok;

	assign tok_w[0] = head_q;
	assign exit_tok = tok_w[CAPACITY];

	for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
		logic signed [sse_pkg::DATA_W-1:0] nb;
		if (i == CAPACITY - 1) begin : g_last
			assign nb = ent_w[i];
		end else begin : g_mid
			assign nb = ent_w[i+1];
		end
		sse_cell #(
			.IDX (i),
			.CW  (CW)
		) u_cell (
			.clk        (clk),
			.arst_n     (arst_n),
			.tok_in     (tok_w[i]),
			.count      (count_q),
			.next_entry (nb),
			.entry      (ent_w[i]),
			.tok_out    (tok_w[i+1])
		);
	end

	always_comb begin
		res_status = exit_tok.hit ? sse_pkg::ST_FOUND : sse_pkg::ST_NOT_FOUND;
		count_nxt  = count_q;
		if (exit_tok.full) begin
			res_status = sse_pkg::ST_FULL;
		end else begin
			case (exit_tok.op)
				sse_pkg::OP_INSERT: begin
					if (exit_tok.hit) begin
						res_status = sse_pkg::ST_DUPLICATE;
					end else begin
						res_status = sse_pkg::ST_INSERTED;
						count_nxt  = count_q + CW'(1);
					end
				end
				sse_pkg::OP_DELETE: begin
					if (exit_tok.hit) begin
						res_status = sse_pkg::ST_DELETED;
						count_nxt  = count_q - CW'(1);
					end
				end
				default: begin
				end
			endcase
		end
		res_cnt_ext = (CW + sse_pkg::COUNT_OUT_W)'(count_nxt);
	end

	assign out_free = !rsp_valid_q || rsp_ready;

	always_comb begin
		state_nxt       = state_q;
		head_nxt        = '0;
		req_ready       = 1'b0;
		load_out        = 1'b0;
		load_pend       = 1'b0;
		from_pend       = 1'b0;
		unique case (state_q)
			sse_pkg::S_IDLE: begin
				req_ready = 1'b1;
				if (req_valid) begin
					head_nxt.active = 1'b1;
					head_nxt.key    = key_value;
					unique case (command)
						sse_pkg::CMD_INSERT: head_nxt.op = sse_pkg::OP_INSERT;
						sse_pkg::CMD_DELETE: head_nxt.op = sse_pkg::OP_DELETE;
						default:             head_nxt.op = sse_pkg::OP_SEARCH;
					endcase
					head_nxt.full = (command == sse_pkg::CMD_INSERT) && (count_q >= CAP_C);
					state_nxt     = sse_pkg::S_BUSY;
				end
			end
			sse_pkg::S_BUSY: begin
				if (exit_tok.active) begin
					if (out_free) begin
						load_out  = 1'b1;
						state_nxt = sse_pkg::S_IDLE;
					end else begin
						load_pend = 1'b1;
						state_nxt = sse_pkg::S_HOLD;
					end
				end
			end
			sse_pkg::S_HOLD: begin
				if (out_free) begin
					load_out  = 1'b1;
					from_pend = 1'b1;
					state_nxt = sse_pkg::S_IDLE;
				end
			end
			default: begin
				state_nxt = sse_pkg::S_IDLE;
			end
		endcase
		rsp_valid_nxt = load_out ? 1'b1 : (rsp_ready ? 1'b0 : rsp_valid_q);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= sse_pkg::S_IDLE;
			head_q      <= '0;
			count_q     <= '0;
			rsp_valid_q <= 1'b0;
		end else begin
			state_q     <= state_nxt;
			head_q      <= head_nxt;
			rsp_valid_q <= rsp_valid_nxt;
			if (state_q == sse_pkg::S_BUSY && exit_tok.active) begin
				count_q <= count_nxt;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (load_pend) begin
			pend_status_q <= res_status;
			pend_cnt_q    <= res_cnt_ext[sse_pkg::COUNT_OUT_W-1:0];
		end
		if (load_out) begin
			if (from_pend) begin
				status_q  <= pend_status_q;
				cnt_out_q <= pend_cnt_q;
			end else begin
				status_q  <= res_status;
				cnt_out_q <= res_cnt_ext[sse_pkg::COUNT_OUT_W-1:0];
			end
		end
	end

	assign rsp_valid   = rsp_valid_q;
	assign status      = status_q;
	assign entry_count = cnt_out_q;

`ifndef NO_ASSERTIONS
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CAP_C)
		else $error("entry count exceeds capacity");

	a_accept_starts_sweep: assert property (@(posedge clk) disable iff (!arst_n)
		req_valid && req_ready |=> head_q.active && state_q == sse_pkg::S_BUSY)
		else $error("accepted request did not enter the cell row");

	a_exit_only_busy: assert property (@(posedge clk) disable iff (!arst_n)
		exit_tok.active |-> state_q == sse_pkg::S_BUSY)
		else $error("request left the cell row outside a sweep");

	a_hold_blocked: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == sse_pkg::S_HOLD |-> rsp_valid_q && !req_ready)
		else $error("parked response without a pending output");
`endif

endmodule

`default_nettype wire
